FILE: src/bovl_pkg.sv
// Shared types and codes for the bounded ordered value list.
`timescale 1ns / 1ps

package bovl_pkg;

   localparam int VALUE_W = 32;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_APPEND = 2'd1;
   localparam logic [1:0] OP_REMOVE = 2'd2;
   localparam logic [1:0] OP_LIST   = 2'd3;

   localparam logic [2:0] STS_DONE      = 3'd0;
   localparam logic [2:0] STS_FULL      = 3'd1;
   localparam logic [2:0] STS_NOT_FOUND = 3'd2;
   localparam logic [2:0] STS_LISTED    = 3'd3;
   localparam logic [2:0] STS_EMPTY     = 3'd4;

   typedef struct packed {
      logic [1:0]         op;
      logic [VALUE_W-1:0] value;
   } cmd_type;

endpackage

FILE: src/bovl_front.sv
// Request intake: accepts requests and queues them as commands for the list engine.
`timescale 1ns / 1ps

module bovl_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [bovl_pkg::VALUE_W-1:0]     req_tdata,   // [31:0] item_value
   input  logic [1:0]                       req_tuser,   // [1:0] req_type
   output logic                             cmd_valid,
   output bovl_pkg::cmd_type                cmd,
   input  logic                             cmd_pop
);

   bovl_pkg::cmd_type slot_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        fill_ff, fill_in;
   logic              push;
   logic              pop;

   assign req_tready = (fill_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign cmd_valid  = (fill_ff != 2'd0);
   assign pop        = cmd_pop && cmd_valid;
   assign cmd        = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff].op    <= req_tuser;
         slot_ff[wr_ptr_ff].value <= req_tdata;
      end
   end

endmodule

FILE: src/bovl_back.sv
// List engine: carries out queued commands on a circular entry store and drives results.
`timescale 1ns / 1ps

module bovl_back #(
   parameter int DEPTH = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             cmd_valid,
   input  bovl_pkg::cmd_type                cmd,
   output logic                             cmd_pop,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [bovl_pkg::VALUE_W-1:0]     rsp_tdata,
   output logic [2:0]                       rsp_tuser,
   output logic                             rsp_tlast
);

   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = CW + 1;

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_LIST_RD = 3'd1;
   localparam logic [2:0] ST_LIST_EM = 3'd2;
   localparam logic [2:0] ST_RM_RD   = 3'd3;
   localparam logic [2:0] ST_RM_CMP  = 3'd4;
   localparam logic [2:0] ST_SH_RD   = 3'd5;
   localparam logic [2:0] ST_SH_WR   = 3'd6;
   localparam logic [2:0] ST_FIN     = 3'd7;

   logic [bovl_pkg::VALUE_W-1:0] mem [DEPTH];
   logic [bovl_pkg::VALUE_W-1:0] rd_data_ff;

   logic [2:0]                   state_ff, state_in;
   logic [CW-1:0]                idx_ff, idx_in;
   logic [CW-1:0]                count_ff, count_in;
   logic [IW-1:0]                head_ff, head_in;
   logic [bovl_pkg::VALUE_W-1:0] val_ff, val_in;
   logic [2:0]                   fin_sts_ff, fin_sts_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [bovl_pkg::VALUE_W-1:0] rsp_data_ff, rsp_data_in;
   logic [2:0]                   rsp_user_ff, rsp_user_in;
   logic                         rsp_last_ff, rsp_last_in;

   logic                         mem_we;
   logic [IW-1:0]                mem_wa;
   logic [bovl_pkg::VALUE_W-1:0] mem_wd;
   logic                         mem_re;
   logic [IW-1:0]                mem_ra;

   logic                         out_free;
   logic                         emit;
   logic [bovl_pkg::VALUE_W-1:0] emit_data;
   logic [2:0]                   emit_user;
   logic                         emit_last;
   logic [CW-1:0]                idx_nx;
   logic [IW-1:0]                head_dec;

   function automatic logic [IW-1:0] phys(input logic [IW-1:0] base,
                                          input logic [CW-1:0] off);
      logic [SW-1:0] s;
      s = SW'(base) + SW'(off);
      if (s >= SW'(DEPTH)) s = s - SW'(DEPTH);
      return s[IW-1:0];
   endfunction

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign idx_nx   = idx_ff + 1'b1;
   assign head_dec = (head_ff == '0) ? IW'(DEPTH - 1) : head_ff - 1'b1;

   always_comb begin
      state_in   = state_ff;
      idx_in     = idx_ff;
      count_in   = count_ff;
      head_in    = head_ff;
      val_in     = val_ff;
      fin_sts_in = fin_sts_ff;
      cmd_pop    = 1'b0;
      mem_we     = 1'b0;
      mem_wa     = '0;
      mem_wd     = '0;
      mem_re     = 1'b0;
      mem_ra     = '0;
      emit       = 1'b0;
      emit_data  = '0;
      emit_user  = bovl_pkg::STS_DONE;
      emit_last  = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid && out_free) begin
               cmd_pop = 1'b1;
               val_in  = cmd.value;
               idx_in  = '0;
               unique case (cmd.op) inside
                  bovl_pkg::OP_INSERT, bovl_pkg::OP_APPEND: begin
                     emit = 1'b1;
                     if (count_ff == CW'(DEPTH)) begin
                        emit_user = bovl_pkg::STS_FULL;
                     end else begin
                        mem_we   = 1'b1;
                        mem_wd   = cmd.value;
                        count_in = count_ff + 1'b1;
                        if (cmd.op == bovl_pkg::OP_INSERT) begin
                           mem_wa  = head_dec;
                           head_in = head_dec;
                        end else begin
                           mem_wa = phys(head_ff, count_ff);
                        end
                     end
                  end
                  bovl_pkg::OP_REMOVE: begin
                     if (count_ff == '0) begin
                        emit      = 1'b1;
                        emit_user = bovl_pkg::STS_NOT_FOUND;
                     end else begin
                        state_in = ST_RM_RD;
                     end
                  end
                  default: begin
                     if (count_ff == '0) begin
                        emit      = 1'b1;
                        emit_user = bovl_pkg::STS_EMPTY;
                     end else begin
                        state_in = ST_LIST_RD;
                     end
                  end
               endcase
            end
         end
         ST_LIST_RD: begin
            mem_re   = 1'b1;
            mem_ra   = phys(head_ff, idx_ff);
            state_in = ST_LIST_EM;
         end
         ST_LIST_EM: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_data = rd_data_ff;
               emit_user = bovl_pkg::STS_LISTED;
               emit_last = (idx_nx == count_ff);
               idx_in    = idx_nx;
               state_in  = (idx_nx == count_ff) ? ST_IDLE : ST_LIST_RD;
            end
         end
         ST_RM_RD: begin
            mem_re   = 1'b1;
            mem_ra   = phys(head_ff, idx_ff);
            state_in = ST_RM_CMP;
         end
         ST_RM_CMP: begin
            if (rd_data_ff == val_ff) begin
               fin_sts_in = bovl_pkg::STS_DONE;
               state_in   = (idx_nx < count_ff) ? ST_SH_RD : ST_FIN;
            end else if (idx_nx == count_ff) begin
               fin_sts_in = bovl_pkg::STS_NOT_FOUND;
               state_in   = ST_FIN;
            end else begin
               idx_in   = idx_nx;
               state_in = ST_RM_RD;
            end
         end
         ST_SH_RD: begin
            mem_re   = 1'b1;
            mem_ra   = phys(head_ff, idx_nx);
            state_in = ST_SH_WR;
         end
         ST_SH_WR: begin
            mem_we   = 1'b1;
            mem_wa   = phys(head_ff, idx_ff);
            mem_wd   = rd_data_ff;
            idx_in   = idx_nx;
            state_in = ((idx_nx + 1'b1) < count_ff) ? ST_SH_RD : ST_FIN;
         end
         ST_FIN: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_user = fin_sts_ff;
               if (fin_sts_ff == bovl_pkg::STS_DONE) begin
                  emit_data = val_ff;
                  count_in  = count_ff - 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = emit_data;
         rsp_user_in  = emit_user;
         rsp_last_in  = emit_last;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         count_ff     <= '0;
         head_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         count_ff     <= count_in;
         head_ff      <= head_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff      <= val_in;
      fin_sts_ff  <= fin_sts_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         rd_data_ff <= mem[mem_ra];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("entry count above depth");

   a_busy_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (count_ff != '0))
      else $error("engine busy on an empty list");

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE && state_ff != ST_FIN) |-> (idx_ff < count_ff))
      else $error("walk index past the end of the list");

   a_pop_only_idle: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> (state_ff == ST_IDLE && out_free))
      else $error("command taken while engine busy");
`endif

endmodule

FILE: src/bounded_ordered_value_list_unit.sv
// Top level of the bounded ordered value list: request queue and list engine.
`timescale 1ns / 1ps

// Keeps up to DEPTH unsigned 32-bit values in order in a circular single-port store.
// A request is registered in the queue before it reaches the engine. Insert-front,
// append-back, a full list, a listing of an empty list and a removal from an
// empty list then finish in the idle state. With a registered store read, a listing
// reads then emits each entry; a removal reads and compares entries in turn, moves
// each later entry up by a read and a write, then emits its result. Up to two
// requests queue ahead of the engine. A single result register drives the result
// channel; the engine takes a new request, and emits each result, only once that
// register is free or being taken, so a stalled result channel stalls the engine.

module bounded_ordered_value_list_unit #(
   parameter int DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] item_value
   input  logic [1:0]  req_tuser,   // [1:0] req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] out_value
   output logic [2:0]  rsp_tuser,   // [2:0] status
   output logic        rsp_tlast
);

   bovl_pkg::cmd_type cmd;
   logic              cmd_valid;
   logic              cmd_pop;

   bovl_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd),
      .cmd_pop    (cmd_pop)
   );

   bovl_back #(
      .DEPTH (DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd),
      .cmd_pop    (cmd_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
